/* rtl/ipsl_pkg.sv */
// Package with shared constants and types for the incremental PID speed loop.
`timescale 1ns / 1ps

package ipsl_pkg;

  localparam int GainFracBits = 8;
  localparam int CountW       = 15;
  localparam int GainW        = 16;
  localparam int ErrW         = 17;
  localparam int DriveW       = 16;
  localparam int DutyW        = 15;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 16;
  localparam int AccW         = CountW + GainFracBits + 2;
  localparam int ProdW        = GainW + ErrW + 3;
  localparam int SumW         = ProdW + 2;
  localparam int BoundW       = CountW + GainFracBits;

  localparam logic [CountW-1:0] TargetReset    = 15'd127;
  localparam logic [GainW-1:0]  KpReset        = 16'd5120;
  localparam logic [GainW-1:0]  KiReset        = 16'd51;
  localparam logic [GainW-1:0]  KdReset        = 16'd0;
  localparam logic [CountW-1:0] LimitReset     = 15'd9999;
  localparam logic [CountW-1:0] OverspeedReset = 15'd1273;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTarget    = 3'd0,
    CfgKp        = 3'd1,
    CfgKi        = 3'd2,
    CfgKd        = 3'd3,
    CfgLimit     = 3'd4,
    CfgOverspeed = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CountW-1:0] target_count;
    logic [GainW-1:0]  kp_gain;
    logic [GainW-1:0]  ki_gain;
    logic [GainW-1:0]  kd_gain;
    logic [CountW-1:0] output_limit;
    logic [CountW-1:0] overspeed_count;
  } cfg_t;

  typedef struct packed {
    logic [AccW-1:0] accumulator;
    logic [ErrW-1:0] error_previous;
    logic [ErrW-1:0] error_before_previous;
    logic            overspeed_latch;
  } loop_state_t;

  typedef struct packed {
    logic [DutyW-1:0]  duty;
    logic [DriveW-1:0] drive_value;
    logic              overspeed;
  } result_t;

endpackage

/* rtl/incremental_pid_speed_loop.sv */
// Incremental PID speed loop with saturating accumulator and sticky overspeed latch.
// A result passes from the input register through the PID datapath into the result
// register. Throughput: one tick per cycle while the output is not stalled, set by the single
// registered pass through the three gain multipliers.
// Reset clears the accumulator, error history and overspeed latch and loads the
// default register values; the block is ready for a transfer right after reset.
`timescale 1ns / 1ps

module incremental_pid_speed_loop (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [15:0]                    encoder_count,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ipsl_pkg::DutyW-1:0]            duty,
  output logic signed [ipsl_pkg::DriveW-1:0]    drive_value,
  output logic                                  overspeed,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipsl_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [ipsl_pkg::CfgDataW-1:0]         cfg_data
);

  ipsl_pkg::cfg_t        cfg;
  ipsl_pkg::loop_state_t state;
  ipsl_pkg::loop_state_t state_next;
  ipsl_pkg::result_t     result_next;
  ipsl_pkg::result_t     result;

  logic                        s1_valid;
  logic [ipsl_pkg::CountW-1:0] s1_count;
  logic                        advance;
  logic                        in_xfer;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_count    <= ipsl_pkg::TargetReset;
      cfg.kp_gain         <= ipsl_pkg::KpReset;
      cfg.ki_gain         <= ipsl_pkg::KiReset;
      cfg.kd_gain         <= ipsl_pkg::KdReset;
      cfg.output_limit    <= ipsl_pkg::LimitReset;
      cfg.overspeed_count <= ipsl_pkg::OverspeedReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ipsl_pkg::CfgTarget:    cfg.target_count    <= cfg_data[ipsl_pkg::CountW-1:0];
        ipsl_pkg::CfgKp:        cfg.kp_gain         <= cfg_data[ipsl_pkg::GainW-1:0];
        ipsl_pkg::CfgKi:        cfg.ki_gain         <= cfg_data[ipsl_pkg::GainW-1:0];
        ipsl_pkg::CfgKd:        cfg.kd_gain         <= cfg_data[ipsl_pkg::GainW-1:0];
        ipsl_pkg::CfgLimit:     cfg.output_limit    <= cfg_data[ipsl_pkg::CountW-1:0];
        ipsl_pkg::CfgOverspeed: cfg.overspeed_count <= cfg_data[ipsl_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: negative counts are taken as zero on the way in.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_count <= encoder_count[15] ? '0 : encoder_count[ipsl_pkg::CountW-1:0];
    end
  end

  ipsl_core u_core (
    .count      (s1_count),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result <= result_next;
    end
  end

  assign duty        = result.duty;
  assign drive_value = result.drive_value;
  assign overspeed   = result.overspeed;

  // The overspeed latch is sticky until reset.
  assert property (@(posedge clk) disable iff (rst)
    state.overspeed_latch |=> state.overspeed_latch)
    else $error("overspeed latch cleared without reset");

  // A nonzero duty only appears with the latch clear and equals the drive value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (duty != '0)) |->
      (!overspeed && (drive_value == $signed({1'b0, duty}))))
    else $error("duty inconsistent with drive value or overspeed");

  // The input side only stalls while the input register holds an item.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // An item leaving the input register lands in the result register.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> out_valid)
    else $error("item lost between input and result registers");

endmodule

/* rtl/ipsl_core.sv */
// Combinational datapath for one control tick: error, PID increment, saturation, outputs.
`timescale 1ns / 1ps

module ipsl_core (
  input  logic [ipsl_pkg::CountW-1:0] count,
  input  ipsl_pkg::cfg_t              cfg,
  input  ipsl_pkg::loop_state_t       state,
  output ipsl_pkg::loop_state_t       state_next,
  output ipsl_pkg::result_t           result
);

  localparam int EW = ipsl_pkg::ErrW;
  localparam int PW = ipsl_pkg::ProdW;
  localparam int SW = ipsl_pkg::SumW;
  localparam int AW = ipsl_pkg::AccW;
  localparam int BW = ipsl_pkg::BoundW;
  localparam int FB = ipsl_pkg::GainFracBits;
  localparam int MW = AW - FB;

  logic                 latch;
  logic [EW-1:0]        err;
  logic signed [EW:0]   d1;
  logic signed [EW+1:0] d2;
  logic signed [EW:0]   ki_err;
  logic signed [PW-1:0] p_kp;
  logic signed [PW-1:0] p_ki;
  logic signed [PW-1:0] p_kd;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] bound_pos;
  logic signed [SW-1:0] bound_neg;
  logic [BW-1:0]        bound;
  logic [AW-1:0]        acc_new;
  logic [AW-1:0]        mag;
  logic [MW-1:0]        mag_int;
  logic [ipsl_pkg::DriveW-1:0] drive_mag;
  logic                 negative;

  always_comb begin
    latch = state.overspeed_latch | (count > cfg.overspeed_count);

    // Target and count are both non-negative 15-bit values, so the error fits 17 bits.
    err = {2'b00, cfg.target_count} - {2'b00, count};
    d1  = {err[EW-1], err} - {state.error_previous[EW-1], state.error_previous};
    d2  = {{2{err[EW-1]}}, err}
        - {state.error_previous[EW-1], state.error_previous, 1'b0}
        + {{2{state.error_before_previous[EW-1]}}, state.error_before_previous};
    ki_err = {err[EW-1], err};

    p_kp = $signed({1'b0, cfg.kp_gain}) * d1;
    p_ki = $signed({1'b0, cfg.ki_gain}) * ki_err;
    p_kd = $signed({1'b0, cfg.kd_gain}) * d2;

    sum = {{(SW-AW){state.accumulator[AW-1]}}, state.accumulator}
        + {{(SW-PW){p_kp[PW-1]}}, p_kp}
        + {{(SW-PW){p_ki[PW-1]}}, p_ki}
        + {{(SW-PW){p_kd[PW-1]}}, p_kd};

    bound     = {cfg.output_limit, {FB{1'b0}}};
    bound_pos = $signed({{(SW-BW){1'b0}}, bound});
    bound_neg = -bound_pos;

    if (sum > bound_pos) begin
      acc_new = bound_pos[AW-1:0];
    end else if (sum < bound_neg) begin
      acc_new = bound_neg[AW-1:0];
    end else begin
      acc_new = sum[AW-1:0];
    end

    // Integer part truncated toward zero: shift the magnitude, then restore the sign.
    negative  = acc_new[AW-1];
    mag       = negative ? (-acc_new) : acc_new;
    mag_int   = mag[AW-1:FB];
    drive_mag = mag_int[ipsl_pkg::DriveW-1:0];

    state_next.accumulator           = acc_new;
    state_next.error_previous        = err;
    state_next.error_before_previous = state.error_previous;
    state_next.overspeed_latch       = latch;

    result.drive_value = negative ? (-drive_mag) : drive_mag;
    result.overspeed   = latch;
    if (!negative && (drive_mag != '0) && !latch) begin
      result.duty = drive_mag[ipsl_pkg::DutyW-1:0];
    end else begin
      result.duty = '0;
    end
  end

endmodule

/* bench/pid_loop_checker.sv */
// Checker that predicts every speed loop tick result and compares it with the block output.
`timescale 1ns / 1ps

module pid_loop_checker
  import ipsl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [15:0]       encoder_count,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [DutyW-1:0]         duty,
  input  logic signed [DriveW-1:0] drive_value,
  input  logic                     overspeed,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgDataW-1:0]      cfg_data,
  output int                       fail_count,
  output int                       ticks_in_flight
);

  cfg_t                   settings;
  logic signed [AccW-1:0] acc;
  logic signed [ErrW-1:0] err_last;
  logic signed [ErrW-1:0] err_older;
  logic                   latched;
  result_t                tick_results_due[$];

  // One control tick: updates the loop state and returns the result it produces.
  function automatic result_t run_pid_tick(input logic signed [15:0] raw);
    logic signed [ErrW-1:0] speed;
    logic signed [ErrW-1:0] err;
    logic signed [47:0]     delta1;
    logic signed [47:0]     delta2;
    logic signed [47:0]     total;
    logic signed [47:0]     bound;
    logic signed [47:0]     mag;
    result_t                res;
    speed = (raw < 0) ? '0 : ErrW'(raw);
    // The latch test comes first, so the tick that sets it already shows zero duty.
    if (speed > $signed({2'b00, settings.overspeed_count})) begin
      latched = 1'b1;
    end
    err = $signed({2'b00, settings.target_count}) - speed;
    delta1 = err - err_last;
    delta2 = err - err_last - err_last + err_older;
    total = acc + $signed({1'b0, settings.kp_gain}) * delta1
          + $signed({1'b0, settings.ki_gain}) * err
          + $signed({1'b0, settings.kd_gain}) * delta2;
    bound = {33'd0, settings.output_limit} <<< GainFracBits;
    if (total > bound) begin
      total = bound;
    end else if (total < -bound) begin
      total = -bound;
    end
    acc = AccW'(total);
    err_older = err_last;
    err_last = err;
    // The integer part is truncated toward zero, not floored.
    mag = (total < 0) ? -total : total;
    mag = mag >>> GainFracBits;
    if (total < 0) begin
      mag = -mag;
    end
    res.drive_value = DriveW'(mag);
    res.duty = (mag > 0 && !latched) ? DutyW'(mag) : '0;
    res.overspeed = latched;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      settings.target_count = TargetReset;
      settings.kp_gain = KpReset;
      settings.ki_gain = KiReset;
      settings.kd_gain = KdReset;
      settings.output_limit = LimitReset;
      settings.overspeed_count = OverspeedReset;
      acc = '0;
      err_last = '0;
      err_older = '0;
      latched = 1'b0;
      fail_count = 0;
      tick_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgTarget:    settings.target_count = cfg_data[CountW-1:0];
          CfgKp:        settings.kp_gain = cfg_data[GainW-1:0];
          CfgKi:        settings.ki_gain = cfg_data[GainW-1:0];
          CfgKd:        settings.kd_gain = cfg_data[GainW-1:0];
          CfgLimit:     settings.output_limit = cfg_data[CountW-1:0];
          CfgOverspeed: settings.overspeed_count = cfg_data[CountW-1:0];
          default:      ;
        endcase
      end
      // Results are retired before new ticks are queued, so a result can never
      // be matched against a tick accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (tick_results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with no tick outstanding (duty %0d, drive %0d)",
                   $time, duty, drive_value);
        end else begin
          want = tick_results_due.pop_front();
          if (duty !== want.duty) begin
            fail_count++;
            $display("%0t: duty expected %0d, got %0d", $time, want.duty, duty);
          end
          if (drive_value !== want.drive_value) begin
            fail_count++;
            $display("%0t: drive_value expected %0d, got %0d", $time,
                     $signed(want.drive_value), drive_value);
          end
          if (overspeed !== want.overspeed) begin
            fail_count++;
            $display("%0t: overspeed expected %0b, got %0b", $time, want.overspeed, overspeed);
          end
        end
      end
      if (in_valid && !in_stall) begin
        tick_results_due.push_back(run_pid_tick(encoder_count));
      end
    end
    ticks_in_flight = tick_results_due.size();
  end

endmodule

/* bench/tb.sv */
// Testbench top that drives the speed loop with directed and random ticks and gives the verdict.
`timescale 1ns / 1ps

module tb;
  import ipsl_pkg::*;

  localparam int QuietLimit = 3000;
  localparam logic [CfgIdxW-1:0] CfgSpareLow  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = 3'd7;
  localparam logic [CountW-1:0]  CountMax     = 15'h7FFF;
  localparam logic [GainW-1:0]   GainMax      = 16'hFFFF;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [15:0]       encoder_count = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DutyW-1:0]         duty;
  logic signed [DriveW-1:0] drive_value;
  logic                     overspeed;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index = '0;
  logic [CfgDataW-1:0]      cfg_data = '0;
  logic                     calm = 1'b0;
  int                       fail_count;
  int                       ticks_in_flight;
  int                       idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  incremental_pid_speed_loop dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .encoder_count(encoder_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty         (duty),
    .drive_value  (drive_value),
    .overspeed    (overspeed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pid_loop_checker loop_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .encoder_count  (encoder_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .duty           (duty),
    .drive_value    (drive_value),
    .overspeed      (overspeed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .ticks_in_flight(ticks_in_flight)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  // Ends the run when no transfer of any kind has happened for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(input logic signed [15:0] count);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    encoder_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [CountW-1:0] goal, input logic [GainW-1:0] kp,
                               input logic [GainW-1:0] ki, input logic [GainW-1:0] kd,
                               input logic [CountW-1:0] limit,
                               input logic [CountW-1:0] threshold);
    write_reg(CfgTarget, {1'b0, goal});
    write_reg(CfgKp, kp);
    write_reg(CfgKi, ki);
    write_reg(CfgKd, kd);
    write_reg(CfgLimit, {1'b0, limit});
    write_reg(CfgOverspeed, {1'b0, threshold});
  endtask

  // Drains the pipeline so that register writes never overlap a tick in flight.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (ticks_in_flight != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [15:0] choose_value(input logic [15:0] top);
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return top;
    if (roll < 6) return 16'($urandom_range(0, int'(top) >> 4));
    return 16'($urandom_range(0, int'(top)));
  endfunction

  // Mostly speeds close to the setpoint, with some arbitrary counts mixed in.
  function automatic logic signed [15:0] speed_sample(input logic [CountW-1:0] goal);
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 15) return 16'($urandom);
    v = int'(goal) + $urandom_range(0, 200) - 100;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  initial begin
    logic [CountW-1:0] goal;
    int                n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: error zero, negative counts, count equal to the threshold.
    send_tick(0);
    send_tick(127);
    send_tick(1);
    send_tick(-1);
    send_tick(-32768);
    send_tick(1273);
    send_tick(700);
    send_tick(0);
    settle();

    // Full-scale gains and swings drive the accumulator into both bounds.
    load_settings(CountMax, GainMax, GainMax, GainMax, CountMax, CountMax);
    send_tick(0);
    send_tick(32767);
    send_tick(0);
    send_tick(32767);
    send_tick(-32768);
    send_tick(0);
    send_tick(0);
    settle();

    // A lowered bound must clip the saturated accumulator on the very next tick.
    write_reg(CfgLimit, 16'd100);
    send_tick(0);
    send_tick(0);
    settle();
    write_reg(CfgLimit, 16'd0);
    send_tick(12345);
    send_tick(-5);
    settle();

    // Writes to unused indexes are dropped; upper data bits of narrow registers are masked.
    write_reg(CfgSpareLow, 16'hFFFF);
    write_reg(CfgSpareHigh, 16'h1234);
    write_reg(CfgTarget, 16'hFFFF);
    write_reg(CfgLimit, 16'h8032);
    write_reg(CfgOverspeed, 16'hFFFF);
    send_tick(32767);
    send_tick(16384);
    settle();

    load_settings('0, '0, '0, '0, CountMax, CountMax);
    send_tick(0);
    send_tick(-7);
    send_tick(300);

    // The threshold stays at its top so the sticky latch is not set until the end.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      calm <= (phase == 3);
      goal = CountW'(choose_value({1'b0, CountMax}));
      load_settings(goal, choose_value(GainMax), choose_value(GainMax), choose_value(GainMax),
                    CountW'(choose_value({1'b0, CountMax})), CountMax);
      for (int i = 0; i < 80; i++) begin
        send_tick(speed_sample(goal));
      end
    end

    // With a threshold of zero, zero and negative counts must not set the latch.
    settle();
    calm <= 1'b0;
    write_reg(CfgOverspeed, 16'd0);
    for (int i = 0; i < 20; i++) begin
      n = $urandom_range(0, 32768);
      send_tick(16'(-n));
    end

    settle();
    goal = CountW'($urandom_range(0, 2000));
    load_settings(goal, choose_value(GainMax), choose_value(GainMax), choose_value(GainMax),
                  CountW'(choose_value({1'b0, CountMax})), CountW'(goal + 15'd20));
    for (int i = 0; i < 60; i++) begin
      send_tick(speed_sample(goal));
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ipsl_pkg.sv
rtl/ipsl_core.sv
rtl/incremental_pid_speed_loop.sv
bench/pid_loop_checker.sv
bench/tb.sv
